[design/ahlt_pkg.sv]
// package with constants, codes and types of the arp host learning table
`timescale 1ns / 1ps
package ahlt_pkg;
    localparam int TableDepth = 256;
    localparam int IdxW = $clog2(TableDepth);
    localparam int CntW = $clog2(TableDepth + 1);
    localparam logic [15:0] ArpEthertype = 16'h0806;
    localparam logic [15:0] OpRequest = 16'd1;
    localparam logic [15:0] OpReply = 16'd2;
    localparam logic [15:0] AgeReset = 16'd300;
    localparam logic [1:0]  AddrAgeLimit = 2'd0;
    localparam int EntryW = 48 + 32 + 8 + 32 + 32;

    typedef enum logic [1:0] {
        CMD_OBSERVE = 2'd0,
        CMD_SWEEP   = 2'd1,
        CMD_READ    = 2'd2,
        CMD_NONE    = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_NOT_ARP = 3'd0,
        ST_BAD_OP  = 3'd1,
        ST_UPDATED = 3'd2,
        ST_ADDED   = 3'd3,
        ST_FULL    = 3'd4,
        ST_SWEPT   = 3'd5,
        ST_READ_OK = 3'd6,
        ST_BAD_IDX = 3'd7
    } t_status;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SEARCH,
        FSM_SWEEP,
        FSM_READ,
        FSM_OUT
    } t_fsm;

    typedef struct packed {
        logic [47:0] mac;
        logic [31:0] ip;
        logic [7:0]  port;
        logic [31:0] seen_time;
        logic [31:0] packets;
    } t_entry;

    // memory port request from controller
    typedef struct packed {
        logic            rd_en;
        logic [IdxW-1:0] rd_addr;
        logic            wr_en;
        logic [IdxW-1:0] wr_addr;
        t_entry          wr_data;
    } t_mem_req;
endpackage

[design/ahlt_ram.sv]
// single table memory, one write and one registered read per cycle
`timescale 1ns / 1ps
module ahlt_ram (
    input  logic              i_clk,
    input  ahlt_pkg::t_mem_req i_req,
    output ahlt_pkg::t_entry  o_rd_data
);
    ahlt_pkg::t_entry r_mem [ahlt_pkg::TableDepth];
    ahlt_pkg::t_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

[design/arp_host_learning_table.sv]
// ARP host learning table: lookup, append, aging sweep and read over one memory
// observe and sweep scan the used entries before the result; read passes through FSM_READ,
// a rejected frame or unused command goes straight to FSM_OUT; one transaction in work at a time
// the table memory port sets the rate: one entry per cycle, up to 256 per item
// result sits in an output register; the next item is taken while it waits for i_ready
// synchronous active low reset clears the count, state and age limit (300); no memory clear
`timescale 1ns / 1ps
module arp_host_learning_table (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_cmd,
    input  logic [15:0] i_eth_type,
    input  logic [15:0] i_arp_opcode,
    input  logic [47:0] i_sender_mac,
    input  logic [31:0] i_sender_ip,
    input  logic [7:0]  i_rx_port,
    input  logic [31:0] i_now_seconds,
    input  logic [7:0]  i_read_index,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [2:0]  o_status,
    output logic [7:0]  o_slot,
    output logic [8:0]  o_entries_in_use,
    output logic [8:0]  o_entries_removed,
    output logic [47:0] o_entry_mac,
    output logic [31:0] o_entry_ip,
    output logic [7:0]  o_entry_port,
    output logic [31:0] o_entry_seen_time,
    output logic [31:0] o_entry_packets
);
    localparam int IdxW = ahlt_pkg::IdxW;
    localparam int CntW = ahlt_pkg::CntW;

    ahlt_pkg::t_fsm r_fsm, n_fsm;
    logic [15:0]     r_age;
    logic [CntW-1:0] r_used, n_used;
    logic [CntW-1:0] r_rd, n_rd;      // next address issued
    logic [CntW-1:0] r_chk, n_chk;    // index of entry now on read data
    logic [CntW-1:0] r_wr, n_wr;      // sweep write pointer
    logic            r_pend, n_pend;  // read data valid for r_chk
    logic [47:0]     r_mac;
    logic [31:0]     r_ip, r_now;
    logic [7:0]      r_port;
    logic            r_ovalid, n_ovalid;
    ahlt_pkg::t_status r_st, n_st;
    logic [7:0]      r_slot, n_slot;
    logic [8:0]      r_rem, n_rem;
    ahlt_pkg::t_entry r_oent, n_oent;
    ahlt_pkg::t_status r_out_st;
    logic [7:0]      r_out_slot;
    logic [CntW-1:0] r_out_used;
    logic [8:0]      r_out_rem;
    ahlt_pkg::t_entry r_out_ent;
    ahlt_pkg::t_mem_req s_req;
    ahlt_pkg::t_entry s_rdata;
    logic s_in_acc, s_cfg_wr, s_busy, s_out_load;
    logic [31:0] s_agediff;

    ahlt_ram u_ram (.i_clk(i_clk), .i_req(s_req), .o_rd_data(s_rdata));

    // configuration port
    assign pready = 1'b1;
    assign s_cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr == ahlt_pkg::AddrAgeLimit) ? {16'd0, r_age} : 32'd0;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_age <= ahlt_pkg::AgeReset;
        end else if (s_cfg_wr && paddr == ahlt_pkg::AddrAgeLimit) begin
            r_age <= pwdata[15:0];
        end
    end

    // input capture
    assign s_busy = (r_fsm != ahlt_pkg::FSM_IDLE);
    assign o_ready = !s_busy;
    assign s_in_acc = i_valid && o_ready;
    always_ff @(posedge i_clk) begin
        if (s_in_acc) begin
            r_mac  <= i_sender_mac;
            r_ip   <= i_sender_ip;
            r_port <= i_rx_port;
            r_now  <= i_now_seconds;
        end
    end

    assign s_agediff = r_now - s_rdata.seen_time;
    assign s_out_load = (r_fsm == ahlt_pkg::FSM_OUT) && (!r_ovalid || i_ready);

    // controller: next state, memory requests, result
    always_comb begin
        n_fsm = r_fsm; n_used = r_used; n_rd = r_rd; n_chk = r_chk; n_wr = r_wr;
        n_pend = 1'b0; n_ovalid = r_ovalid; n_st = r_st; n_slot = r_slot;
        n_rem = r_rem; n_oent = r_oent;
        s_req = '0;
        if (r_ovalid && i_ready) n_ovalid = 1'b0;
        unique case (r_fsm)
            ahlt_pkg::FSM_IDLE: begin
                if (s_in_acc) begin
                    n_slot = '0; n_rem = '0; n_oent = '0;
                    n_rd = '0; n_chk = '0; n_wr = '0;
                    unique case (ahlt_pkg::t_cmd'(i_cmd))
                        ahlt_pkg::CMD_OBSERVE: begin
                            if (i_eth_type != ahlt_pkg::ArpEthertype) begin
                                n_st = ahlt_pkg::ST_NOT_ARP; n_fsm = ahlt_pkg::FSM_OUT;
                            end else if (i_arp_opcode != ahlt_pkg::OpRequest
                                         && i_arp_opcode != ahlt_pkg::OpReply) begin
                                n_st = ahlt_pkg::ST_BAD_OP; n_fsm = ahlt_pkg::FSM_OUT;
                            end else begin
                                n_fsm = ahlt_pkg::FSM_SEARCH;
                            end
                        end
                        ahlt_pkg::CMD_SWEEP: n_fsm = ahlt_pkg::FSM_SWEEP;
                        ahlt_pkg::CMD_READ: begin
                            if ({1'b0, i_read_index} >= CntW'(r_used)) begin
                                n_st = ahlt_pkg::ST_BAD_IDX; n_fsm = ahlt_pkg::FSM_OUT;
                            end else begin
                                s_req.rd_en = 1'b1;
                                s_req.rd_addr = i_read_index[IdxW-1:0];
                                n_slot = i_read_index;
                                n_fsm = ahlt_pkg::FSM_READ;
                            end
                        end
                        default: begin
                            n_st = ahlt_pkg::ST_BAD_IDX; n_fsm = ahlt_pkg::FSM_OUT;
                        end
                    endcase
                end
            end
            ahlt_pkg::FSM_READ: begin
                n_st = ahlt_pkg::ST_READ_OK;
                n_oent = s_rdata;
                n_fsm = ahlt_pkg::FSM_OUT;
            end
            ahlt_pkg::FSM_SEARCH: begin
                // one compare per cycle against the registered read data
                if (r_pend && s_rdata.mac == r_mac) begin
                    s_req.wr_en = 1'b1;
                    s_req.wr_addr = r_chk[IdxW-1:0];
                    s_req.wr_data = s_rdata;
                    s_req.wr_data.seen_time = r_now;
                    if (s_rdata.packets != 32'hFFFF_FFFF)
                        s_req.wr_data.packets = s_rdata.packets + 32'd1;
                    n_st = ahlt_pkg::ST_UPDATED;
                    n_slot = 8'(r_chk);
                    n_fsm = ahlt_pkg::FSM_OUT;
                end else begin
                    if (r_pend) n_chk = r_chk + 1'b1;
                    if (r_rd < r_used) begin
                        s_req.rd_en = 1'b1;
                        s_req.rd_addr = r_rd[IdxW-1:0];
                        n_rd = r_rd + 1'b1;
                        n_pend = 1'b1;
                    end else if (!r_pend) begin
                        if (r_used < CntW'(ahlt_pkg::TableDepth)) begin
                            s_req.wr_en = 1'b1;
                            s_req.wr_addr = r_used[IdxW-1:0];
                            s_req.wr_data = '{mac: r_mac, ip: r_ip, port: r_port,
                                              seen_time: r_now, packets: 32'd1};
                            n_slot = 8'(r_used);
                            n_used = r_used + 1'b1;
                            n_st = ahlt_pkg::ST_ADDED;
                        end else begin
                            n_st = ahlt_pkg::ST_FULL;
                        end
                        n_fsm = ahlt_pkg::FSM_OUT;
                    end
                end
            end
            ahlt_pkg::FSM_SWEEP: begin
                // wr never passes rd, so compaction writes never hit unread entries
                if (r_pend) begin
                    n_chk = r_chk + 1'b1;
                    if (s_agediff > {16'd0, r_age}) begin
                        n_rem = r_rem + 1'b1;
                    end else begin
                        s_req.wr_en = (r_wr != r_chk);
                        s_req.wr_addr = r_wr[IdxW-1:0];
                        s_req.wr_data = s_rdata;
                        n_wr = r_wr + 1'b1;
                    end
                end
                if (r_rd < r_used) begin
                    s_req.rd_en = 1'b1;
                    s_req.rd_addr = r_rd[IdxW-1:0];
                    n_rd = r_rd + 1'b1;
                    n_pend = 1'b1;
                end else if (!r_pend) begin
                    n_used = r_wr;
                    n_st = ahlt_pkg::ST_SWEPT;
                    n_fsm = ahlt_pkg::FSM_OUT;
                end
            end
            ahlt_pkg::FSM_OUT: begin
                // hand the result over once the output register is free
                if (s_out_load) begin
                    n_ovalid = 1'b1;
                    n_fsm = ahlt_pkg::FSM_IDLE;
                end
            end
            default: n_fsm = ahlt_pkg::FSM_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= ahlt_pkg::FSM_IDLE;
            r_used <= '0;
            r_pend <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            r_used <= n_used;
            r_pend <= n_pend;
            r_ovalid <= n_ovalid;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_rd <= n_rd; r_chk <= n_chk; r_wr <= n_wr;
        r_st <= n_st; r_slot <= n_slot; r_rem <= n_rem; r_oent <= n_oent;
    end

    // output register, holds the result while the next item is worked on
    always_ff @(posedge i_clk) begin
        if (s_out_load) begin
            r_out_st <= r_st;
            r_out_slot <= r_slot;
            r_out_used <= r_used;
            r_out_rem <= r_rem;
            r_out_ent <= r_oent;
        end
    end

    // result outputs
    assign o_valid = r_ovalid;
    assign o_status = r_out_st;
    assign o_slot = r_out_slot;
    assign o_entries_in_use = 9'(r_out_used);
    assign o_entries_removed = r_out_rem;
    assign o_entry_mac = r_out_ent.mac;
    assign o_entry_ip = r_out_ent.ip;
    assign o_entry_port = r_out_ent.port;
    assign o_entry_seen_time = r_out_ent.seen_time;
    assign o_entry_packets = r_out_ent.packets;

    // checks
    a_used_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CntW'(ahlt_pkg::TableDepth)) else $error("used count overflow");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid && !i_ready |=> r_ovalid && $stable(r_out_st) && $stable(r_out_ent))
        else $error("result changed while waiting");
    a_wr_behind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fsm == ahlt_pkg::FSM_SWEEP |-> r_wr <= r_chk) else $error("sweep overtakes");
    a_added_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fsm == ahlt_pkg::FSM_SEARCH && n_st == ahlt_pkg::ST_ADDED
         && n_fsm == ahlt_pkg::FSM_OUT) |=> r_used == $past(r_used) + 1'b1)
        else $error("add without count");
endmodule
